// ----- design/abpw_pkg.sv -----
// Package for the alpha blend pixel writer: shared types, codes and color helpers.
// Used by the top level, front, queue and back modules; depends on nothing.
`default_nettype none
package abpw_pkg;

  localparam int WIDX_W = 28;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_LOAD = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_LOADED  = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_VIS_W   = 3'd0,
    REG_VIS_H   = 3'd1,
    REG_PAN_X   = 3'd2,
    REG_PAN_Y   = 3'd3,
    REG_FORMAT  = 3'd4,
    REG_PITCH   = 3'd5,
    REG_SCREEN  = 3'd6,
    REG_SPARE   = 3'd7
  } reg_idx_t;

  localparam logic [1:0] FMT_32BPP = 2'd0;
  localparam logic [1:0] FMT_565   = 2'd1;

  typedef enum logic [1:0] {
    K_SKIP = 2'd0,
    K_LOAD = 2'd1,
    K_READ = 2'd2,
    K_DRAW = 2'd3
  } kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [11:0] vis_w;
    logic [11:0] vis_h;
    logic [11:0] pan_x;
    logic [11:0] pan_y;
    logic [1:0]  format;
    logic [15:0] pitch;
    logic [16:0] screen;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic [WIDX_W-1:0]  widx;
    logic               half;
    logic               fmt16;
    logic               direct;
    logic [7:0]         alpha;
    logic [31:0]        data;
  } entry_t;

  function automatic logic [15:0] to565(input logic [31:0] c);
    to565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [31:0] expand565(input logic [15:0] p);
    expand565 = {8'd0, p[15:11], 3'd0, p[10:5], 2'd0, p[4:0], 3'd0};
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                     input logic [7:0] a);
    logic [16:0] sum;
    sum = 17'(fg * {1'b0, a}) + 17'(bg * (9'd256 - {1'b0, a}));
    mix = sum[15:8];
  endfunction

endpackage
`default_nettype wire

// ----- design/alpha_blend_pixel_writer_core.sv -----
// Top level of the alpha blend pixel writer: configuration registers, front, queue and back.
// Depends on abpw_pkg, abpw_front, abpw_queue and abpw_back.
//
// Draws, loads and reads one item at a time against a single-port frame store of
// BUFFER_WORDS words. An item passes the front register, a four-entry queue that
// separates intake from the store, the back part's IDLE state (pop and store read),
// its EXEC state (store write or result) and the result register; no new item is popped
// before EXEC ends, nor while a result beat waits. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module alpha_blend_pixel_writer_core #(
  parameter int BUFFER_WORDS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [11:0] in_pos_x,
  input  wire logic [11:0] in_pos_y,
  input  wire logic [31:0] in_pixel_color,
  input  wire logic [8:0]  in_opacity,
  input  wire logic [13:0] in_word_index,
  input  wire logic [31:0] in_load_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_read_data
);
  abpw_pkg::cfg_t   cfg_r;
  abpw_pkg::entry_t q_in, q_head;
  logic             q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vis_w  <= 12'd640;
      cfg_r.vis_h  <= 12'd480;
      cfg_r.pan_x  <= 12'd0;
      cfg_r.pan_y  <= 12'd0;
      cfg_r.format <= abpw_pkg::FMT_32BPP;
      cfg_r.pitch  <= 16'd2560;
      cfg_r.screen <= 17'd65536;
    end else if (cfg_we) begin
      unique case (abpw_pkg::reg_idx_t'(cfg_index))
        abpw_pkg::REG_VIS_W:  cfg_r.vis_w  <= cfg_wdata[11:0];
        abpw_pkg::REG_VIS_H:  cfg_r.vis_h  <= cfg_wdata[11:0];
        abpw_pkg::REG_PAN_X:  cfg_r.pan_x  <= cfg_wdata[11:0];
        abpw_pkg::REG_PAN_Y:  cfg_r.pan_y  <= cfg_wdata[11:0];
        abpw_pkg::REG_FORMAT: cfg_r.format <= cfg_wdata[1:0];
        abpw_pkg::REG_PITCH:  cfg_r.pitch  <= cfg_wdata[15:0];
        abpw_pkg::REG_SCREEN: cfg_r.screen <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  abpw_front #(.BUFFER_WORDS(BUFFER_WORDS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_color (in_pixel_color),
    .in_opacity     (in_opacity),
    .in_word_index  (in_word_index),
    .in_load_data   (in_load_data),
    .q_push         (q_push),
    .q_data         (q_in),
    .q_full         (q_full)
  );

  abpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  abpw_back #(.BUFFER_WORDS(BUFFER_WORDS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );
endmodule
`default_nettype wire

// ----- design/abpw_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module abpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- design/abpw_queue.sv -----
// Short queue of classified items between the front and back parts.
// Depends on abpw_pkg.
`default_nettype none
module abpw_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire abpw_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output abpw_pkg::entry_t     head,
  output logic                 empty
);
  localparam int PW = $clog2(abpw_pkg::QUEUE_DEPTH);

  abpw_pkg::entry_t mem_r [abpw_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full  = (count_r == (PW+1)'(abpw_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- design/abpw_front.sv -----
// Front part: accepts items, clips and addresses draws, and queues the classified entry.
// Depends on abpw_pkg.
`default_nettype none
module abpw_front #(
  parameter int BUFFER_WORDS = 16384
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire abpw_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_operation,
  input  wire logic [11:0]       in_pos_x,
  input  wire logic [11:0]       in_pos_y,
  input  wire logic [31:0]       in_pixel_color,
  input  wire logic [8:0]        in_opacity,
  input  wire logic [13:0]       in_word_index,
  input  wire logic [31:0]       in_load_data,
  output logic                   q_push,
  output abpw_pkg::entry_t       q_data,
  input  wire logic              q_full
);
  localparam logic [abpw_pkg::WIDX_W-1:0] LIMIT = abpw_pkg::WIDX_W'(BUFFER_WORDS);

  logic        s1_v_r;
  logic [1:0]  op_r;
  logic [31:0] data_r;
  logic        direct_r, fmt16_r, early_skip_r;
  logic [7:0]  alpha_r;
  logic [13:0] widx_r;
  logic [14:0] xprod_r;
  logic [28:0] yprod_r;

  logic        accept, fmt16, early_skip;
  logic [12:0] xsum, ysum;
  logic [15:0] pitch4;
  logic [29:0] loc;
  logic [abpw_pkg::WIDX_W-1:0] word, widx_ext;

  assign in_stall = s1_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_v_r && !q_full;

  assign fmt16  = (cfg.format == abpw_pkg::FMT_565);
  assign xsum   = 13'(in_pos_x) + 13'(cfg.pan_x);
  assign ysum   = 13'(in_pos_y) + 13'(cfg.pan_y);
  assign pitch4 = {cfg.pitch[15:2], 2'b00};
  assign early_skip = (in_pos_x >= cfg.vis_w) || (in_pos_y >= cfg.vis_h) ||
                      (in_opacity == 9'd0) ||
                      (cfg.format != abpw_pkg::FMT_32BPP && !fmt16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_operation;
      data_r       <= (in_operation == abpw_pkg::OP_LOAD) ? in_load_data : in_pixel_color;
      direct_r     <= in_opacity[8];
      alpha_r      <= in_opacity[7:0];
      fmt16_r      <= fmt16;
      early_skip_r <= early_skip;
      widx_r       <= in_word_index;
      xprod_r      <= fmt16 ? {1'b0, xsum, 1'b0} : {xsum, 2'b00};
      yprod_r      <= 29'(ysum * pitch4);
    end
  end

  assign loc      = 30'(xprod_r) + 30'(yprod_r);
  assign word     = loc[29:2];
  assign widx_ext = abpw_pkg::WIDX_W'(widx_r);

  always_comb begin
    q_data        = '0;
    q_data.data   = data_r;
    q_data.alpha  = alpha_r;
    q_data.direct = direct_r;
    q_data.fmt16  = fmt16_r;
    q_data.half   = loc[1];
    unique case (op_r)
      abpw_pkg::OP_DRAW: begin
        q_data.widx = word;
        q_data.hit  = 1'b1;
        if (early_skip_r || loc >= 30'(cfg.screen) || word >= LIMIT) begin
          q_data.kind = abpw_pkg::K_SKIP;
        end else begin
          q_data.kind = abpw_pkg::K_DRAW;
        end
      end
      abpw_pkg::OP_LOAD: begin
        q_data.kind = abpw_pkg::K_LOAD;
        q_data.widx = widx_ext;
        q_data.hit  = widx_ext < LIMIT;
      end
      abpw_pkg::OP_READ: begin
        q_data.kind = abpw_pkg::K_READ;
        q_data.widx = widx_ext;
        q_data.hit  = widx_ext < LIMIT;
      end
      default: begin
        q_data.kind = abpw_pkg::K_SKIP;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- design/abpw_back.sv -----
// Back part: reads the frame store, blends, writes back and presents the result beat.
// Depends on abpw_pkg and abpw_ram.
`default_nettype none
module abpw_back #(
  parameter int BUFFER_WORDS = 16384
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire abpw_pkg::entry_t q_head,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [31:0]           out_read_data
);
  localparam int AW = $clog2(BUFFER_WORDS);

  abpw_pkg::back_state_t state_r, state_nxt;
  abpw_pkg::entry_t      cur_r, cur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [31:0]           out_read_data_r, out_read_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [31:0]   bg, blended, pix;
  logic [15:0]   c16;

  abpw_ram #(.WIDTH(32), .DEPTH(BUFFER_WORDS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ram_addr = (state_r == abpw_pkg::S_IDLE) ? q_head.widx[AW-1:0] : cur_r.widx[AW-1:0];

  assign bg = cur_r.fmt16 ?
              abpw_pkg::expand565(cur_r.half ? ram_rdata[31:16] : ram_rdata[15:0]) : ram_rdata;
  assign blended = {8'd0,
                    abpw_pkg::mix(cur_r.data[23:16], bg[23:16], cur_r.alpha),
                    abpw_pkg::mix(cur_r.data[15:8], bg[15:8], cur_r.alpha),
                    abpw_pkg::mix(cur_r.data[7:0], bg[7:0], cur_r.alpha)};
  assign pix = cur_r.direct ? cur_r.data : blended;
  assign c16 = abpw_pkg::to565(pix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abpw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r           <= cur_nxt;
    out_status_r    <= out_status_nxt;
    out_read_data_r <= out_read_data_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    cur_nxt           = cur_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_read_data_nxt = out_read_data_r;
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_wdata         = cur_r.data;
    unique case (state_r)
      abpw_pkg::S_IDLE: begin
        if (!q_empty && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = abpw_pkg::S_EXEC;
        end
      end
      abpw_pkg::S_EXEC: begin
        state_nxt         = abpw_pkg::S_IDLE;
        out_valid_nxt     = 1'b1;
        out_read_data_nxt = '0;
        case (cur_r.kind)
          abpw_pkg::K_LOAD: begin
            ram_we         = cur_r.hit;
            out_status_nxt = abpw_pkg::ST_LOADED;
          end
          abpw_pkg::K_READ: begin
            out_status_nxt    = abpw_pkg::ST_READ;
            out_read_data_nxt = cur_r.hit ? ram_rdata : 32'd0;
          end
          abpw_pkg::K_DRAW: begin
            ram_we         = 1'b1;
            out_status_nxt = abpw_pkg::ST_WRITTEN;
            if (!cur_r.fmt16) begin
              ram_wdata = pix;
            end else if (cur_r.half) begin
              ram_wdata = {c16, ram_rdata[15:0]};
            end else begin
              ram_wdata = {ram_rdata[31:16], c16};
            end
          end
          default: begin
            out_status_nxt = abpw_pkg::ST_SKIPPED;
          end
        endcase
      end
      default: begin
        state_nxt = abpw_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

  a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == abpw_pkg::S_EXEC |-> !out_valid_r)
    else $error("result register busy while an item executes");
  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == abpw_pkg::S_EXEC)
    else $error("store written outside execution");
  a_pop_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == abpw_pkg::S_EXEC)
    else $error("popped entry not executed");
  a_beat_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == abpw_pkg::S_EXEC)
    else $error("result beat without execution");
endmodule
`default_nettype wire
